>>> rtl/core/animated_sprite_blitter_unit_macros.svh
// assertion macros shared by the sprite blitter modules
// they expect clk_i and rst_ni in the scope of use
`ifndef ANIMATED_SPRITE_BLITTER_UNIT_MACROS_SVH
`define ANIMATED_SPRITE_BLITTER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASBU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("asbu assertion failed");
`define ASBU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("asbu assertion failed");
`else
`define ASBU_ASSERT_IMP(lbl, ante, cons)
`define ASBU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/asbu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package asbu_pkg;

  localparam int unsigned MaxSpriteWidth  = 8;
  localparam int unsigned MaxSpriteHeight = 8;
  localparam int unsigned MaxFrames       = 8;
  localparam int unsigned ScreenCols      = 128;
  localparam int unsigned ScreenRows      = 64;

  localparam int unsigned FrameSlot  = MaxSpriteWidth * MaxSpriteHeight;
  localparam int unsigned StoreDepth = MaxFrames * FrameSlot;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);
  localparam int unsigned FrameW     = $clog2(MaxFrames);
  localparam int unsigned ColW       = $clog2(MaxSpriteWidth);
  localparam int unsigned RowW       = $clog2(MaxSpriteHeight);

  localparam int unsigned ScreenAw  = 13;
  localparam int unsigned GlyphW    = 16;
  localparam int unsigned SizeW     = 4;
  localparam int unsigned PeriodW   = 10;
  localparam int unsigned OriginW   = 8;
  localparam int unsigned PosW      = 16;
  localparam int unsigned ElapsedW  = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 10;

  localparam logic [GlyphW-1:0] SpaceGlyph = 16'h0020;
  localparam logic [PeriodW-1:0] PeriodReset = 10'd1000;

  localparam logic ActLoad = 1'b0;
  localparam logic ActDraw = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgSpriteWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSpriteHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFrameCount   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFramePeriod  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTransparent  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgOriginX      = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgOriginY      = 3'd6;

  typedef struct packed {
    logic signed [PosW:0] x0;
    logic signed [PosW:0] y0;
    logic [SizeW-1:0]     width;
    logic [SizeW-1:0]     height;
    logic                 transparent;
    logic [FrameW-1:0]    frame;
  } draw_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/asbu_glyph_store.sv
`timescale 1ns / 1ps
`default_nettype none

module asbu_glyph_store (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [asbu_pkg::StoreAw-1:0]  waddr_i,
  input  logic [asbu_pkg::GlyphW-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [asbu_pkg::StoreAw-1:0]  raddr_i,
  output logic [asbu_pkg::GlyphW-1:0]   rdata_o
);
  import asbu_pkg::*;

  logic [GlyphW-1:0] mem_q [StoreDepth];
  logic [GlyphW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/asbu_frame_div.sv
`timescale 1ns / 1ps
`default_nettype none

module asbu_frame_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [asbu_pkg::ElapsedW-1:0]  dividend_i,
  input  logic [asbu_pkg::PeriodW-1:0]   divisor_i,
  input  logic [asbu_pkg::SizeW-1:0]     modulus_i,
  output logic                           done_o,
  output logic [asbu_pkg::FrameW-1:0]    frame_o
);
  import asbu_pkg::*;

  localparam int unsigned CntW = $clog2(ElapsedW);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [ElapsedW-1:0] dvd_q, dvd_d;
  logic [PeriodW-1:0]  rem_q, rem_d;
  logic [FrameW-1:0]   mod_q, mod_d;
  logic [PeriodW-1:0]  divisor_q, divisor_d;
  logic [SizeW-1:0]    modulus_q, modulus_d;

  logic [PeriodW:0]    trial;
  logic                ge;
  logic [SizeW-1:0]    m2;

  // restoring division, one quotient bit per cycle; the quotient itself is
  // never kept, only its running residue modulo the frame count
  always_comb begin
    trial = {rem_q, dvd_q[ElapsedW-1]};
    ge    = trial >= {1'b0, divisor_q};
    m2    = SizeW'({mod_q, ge});

    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    mod_d     = mod_q;
    divisor_d = divisor_q;
    modulus_d = modulus_q;

    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = CntW'(ElapsedW - 1);
      dvd_d     = dividend_i;
      rem_d     = '0;
      mod_d     = '0;
      divisor_d = divisor_i;
      modulus_d = modulus_i;
    end else if (busy_q) begin
      rem_d = ge ? PeriodW'(trial - {1'b0, divisor_q}) : trial[PeriodW-1:0];
      // 2*m + bit stays below twice the modulus
      mod_d = (m2 >= modulus_q) ? FrameW'(m2 - modulus_q) : FrameW'(m2);
      dvd_d = {dvd_q[ElapsedW-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    mod_q     <= mod_d;
    divisor_q <= divisor_d;
    modulus_q <= modulus_d;
  end

  assign done_o  = done_q;
  assign frame_o = mod_q;

endmodule

`default_nettype wire

>>> rtl/core/asbu_pixel_walk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "animated_sprite_blitter_unit_macros.svh"

module asbu_pixel_walk (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  asbu_pkg::draw_cmd_t            cmd_i,
  output logic                           done_o,
  output logic                           rd_en_o,
  output logic [asbu_pkg::StoreAw-1:0]   rd_addr_o,
  input  logic [asbu_pkg::GlyphW-1:0]    rd_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [asbu_pkg::ScreenAw-1:0]  screen_address_o,
  output logic [asbu_pkg::GlyphW-1:0]    glyph_out_o,
  output logic [asbu_pkg::FrameW-1:0]    frame_index_o,
  output logic                           last_o
);
  import asbu_pkg::*;

  draw_cmd_t           cmd_q, cmd_d;
  logic                act_q, act_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [ColW-1:0]     col_q, col_d;
  logic [StoreAw-1:0]  ptr_q, ptr_d;

  // read stage: glyph arrives from the store in the cycle after issue
  logic                b_valid_q, b_valid_d;
  logic                b_on_q, b_on_d;
  logic                b_end_q, b_end_d;
  logic [ScreenAw-1:0] b_sa_q, b_sa_d;
  logic                flush_q, flush_d;

  // one write is held back until the next one shows it was not the last
  logic                h_valid_q, h_valid_d;
  logic [ScreenAw-1:0] h_sa_q, h_sa_d;
  logic [GlyphW-1:0]   h_glyph_q, h_glyph_d;

  logic                o_valid_q, o_valid_d;
  logic [ScreenAw-1:0] o_sa_q, o_sa_d;
  logic [GlyphW-1:0]   o_glyph_q, o_glyph_d;
  logic [FrameW-1:0]   o_frame_q, o_frame_d;
  logic                o_last_q, o_last_d;

  logic                  go;
  logic signed [PosW+1:0] px, py;
  logic                  on_screen;
  logic [ScreenAw-1:0]   sa;
  logic                  col_end, last_pix, cand, load_o;

  always_comb begin
    go = !o_valid_q || !out_stall_i;

    px = {cmd_q.x0[PosW], cmd_q.x0} + (PosW+2)'(col_q);
    py = {cmd_q.y0[PosW], cmd_q.y0} + (PosW+2)'(row_q);
    on_screen = !px[PosW+1] && (px < (PosW+2)'(ScreenCols)) &&
                !py[PosW+1] && (py < (PosW+2)'(ScreenRows));
    sa = ScreenAw'(py) * ScreenAw'(ScreenCols) + ScreenAw'(px);

    col_end  = SizeW'(col_q) == cmd_q.width - SizeW'(1);
    last_pix = col_end && (SizeW'(row_q) == cmd_q.height - SizeW'(1));
    cand     = b_valid_q && b_on_q &&
               !(cmd_q.transparent && (rd_data_i == SpaceGlyph));

    rd_en_o   = go && act_q;
    rd_addr_o = ptr_q;

    cmd_d     = cmd_q;
    act_d     = act_q;
    row_d     = row_q;
    col_d     = col_q;
    ptr_d     = ptr_q;
    b_valid_d = b_valid_q;
    b_on_d    = b_on_q;
    b_end_d   = b_end_q;
    b_sa_d    = b_sa_q;
    flush_d   = flush_q;
    h_valid_d = h_valid_q;
    h_sa_d    = h_sa_q;
    h_glyph_d = h_glyph_q;
    o_valid_d = o_valid_q;
    o_sa_d    = o_sa_q;
    o_glyph_d = o_glyph_q;
    o_frame_d = o_frame_q;
    o_last_d  = o_last_q;
    load_o    = 1'b0;

    if (go) begin
      if (act_q) begin
        col_d = col_end ? '0 : col_q + ColW'(1);
        row_d = col_end ? row_q + RowW'(1) : row_q;
        ptr_d = ptr_q + StoreAw'(1);
        act_d = !last_pix;
      end
      b_valid_d = act_q;
      b_on_d    = on_screen;
      b_end_d   = last_pix;
      b_sa_d    = sa;
      flush_d   = b_valid_q && b_end_q;

      if (flush_q) begin
        if (h_valid_q) begin
          load_o    = 1'b1;
          o_last_d  = 1'b1;
          h_valid_d = 1'b0;
        end
      end else if (cand) begin
        if (h_valid_q) begin
          load_o   = 1'b1;
          o_last_d = 1'b0;
        end
        h_valid_d = 1'b1;
        h_sa_d    = b_sa_q;
        h_glyph_d = rd_data_i;
      end

      o_valid_d = load_o;
      if (load_o) begin
        o_sa_d    = h_sa_q;
        o_glyph_d = h_glyph_q;
        o_frame_d = cmd_q.frame;
      end
    end

    if (start_i) begin
      cmd_d = cmd_i;
      act_d = 1'b1;
      row_d = '0;
      col_d = '0;
      ptr_d = StoreAw'(cmd_i.frame) * StoreAw'(FrameSlot);
    end

    done_o = go && flush_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      b_valid_q <= 1'b0;
      flush_q   <= 1'b0;
      h_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      act_q     <= act_d;
      b_valid_q <= b_valid_d;
      flush_q   <= flush_d;
      h_valid_q <= h_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    row_q     <= row_d;
    col_q     <= col_d;
    ptr_q     <= ptr_d;
    b_on_q    <= b_on_d;
    b_end_q   <= b_end_d;
    b_sa_q    <= b_sa_d;
    h_sa_q    <= h_sa_d;
    h_glyph_q <= h_glyph_d;
    o_sa_q    <= o_sa_d;
    o_glyph_q <= o_glyph_d;
    o_frame_q <= o_frame_d;
    o_last_q  <= o_last_d;
  end

  assign out_valid_o      = o_valid_q;
  assign screen_address_o = o_sa_q;
  assign glyph_out_o      = o_glyph_q;
  assign frame_index_o    = o_frame_q;
  assign last_o           = o_last_q;

  `ASBU_ASSERT_IMP(a_start_when_empty, start_i,
                   !act_q && !b_valid_q && !flush_q && !h_valid_q)
  `ASBU_ASSERT_NEXT(a_flush_drains, done_o, !h_valid_q && !flush_q && !b_valid_q)
  `ASBU_ASSERT_IMP(a_ptr_in_frame, act_q, ptr_q[StoreAw-1 -: FrameW] == cmd_q.frame)

endmodule

`default_nettype wire

>>> rtl/core/animated_sprite_blitter_unit.sv
// a load transaction writes one glyph store entry
// a draw first selects the frame with a divider that retires one quotient bit
// a cycle over 32 bits, then makes one glyph store read per sprite pixel
// and then drains its output pipeline
// the next transaction is accepted once the draw is done; results may still wait
// reset sets the registers to 1, 1, 1, 1000, 0, 0, 0; the glyph store is not cleared
`timescale 1ns / 1ps
`default_nettype none

`include "animated_sprite_blitter_unit_macros.svh"

module animated_sprite_blitter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic [asbu_pkg::StoreAw-1:0]        load_address_i,
  input  logic [asbu_pkg::GlyphW-1:0]         glyph_in_i,
  input  logic signed [asbu_pkg::PosW-1:0]    pos_x_i,
  input  logic signed [asbu_pkg::PosW-1:0]    pos_y_i,
  input  logic [asbu_pkg::ElapsedW-1:0]       elapsed_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [asbu_pkg::ScreenAw-1:0]       screen_address_o,
  output logic [asbu_pkg::GlyphW-1:0]         glyph_out_o,
  output logic [asbu_pkg::FrameW-1:0]         frame_index_o,
  output logic                                last_o,
  input  logic                                cfg_we_i,
  input  logic [asbu_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [asbu_pkg::CfgDataW-1:0]       cfg_data_i
);
  import asbu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_WALK
  } state_e;

  state_e state_q, state_d;

  logic [SizeW-1:0]          cfg_width_q, cfg_height_q, cfg_frames_q;
  logic [PeriodW-1:0]        cfg_period_q;
  logic                      cfg_transp_q;
  logic signed [OriginW-1:0] cfg_org_x_q, cfg_org_y_q;

  logic signed [PosW:0] x0_q, y0_q;

  logic                 accept, div_start, div_done, walk_start, walk_done;
  logic [FrameW-1:0]    div_frame;
  logic [SizeW-1:0]     w_eff, h_eff, nf_eff;
  logic [PeriodW-1:0]   period_eff;
  draw_cmd_t            cmd;

  logic                 rd_en;
  logic [StoreAw-1:0]   rd_addr;
  logic [GlyphW-1:0]    rd_data;

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign div_start  = accept && (action_i == ActDraw);
  assign walk_start = (state_q == S_DIV) && div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= SizeW'(1);
      cfg_height_q <= SizeW'(1);
      cfg_frames_q <= SizeW'(1);
      cfg_period_q <= PeriodReset;
      cfg_transp_q <= 1'b0;
      cfg_org_x_q  <= '0;
      cfg_org_y_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSpriteWidth:  cfg_width_q  <= cfg_data_i[SizeW-1:0];
        CfgSpriteHeight: cfg_height_q <= cfg_data_i[SizeW-1:0];
        CfgFrameCount:   cfg_frames_q <= cfg_data_i[SizeW-1:0];
        CfgFramePeriod:  cfg_period_q <= cfg_data_i[PeriodW-1:0];
        CfgTransparent:  cfg_transp_q <= cfg_data_i[0];
        CfgOriginX:      cfg_org_x_q  <= cfg_data_i[OriginW-1:0];
        CfgOriginY:      cfg_org_y_q  <= cfg_data_i[OriginW-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range sizes and frame counts saturate, a zero period acts as one
  always_comb begin
    w_eff = (cfg_width_q == '0) ? SizeW'(1) :
            (cfg_width_q > SizeW'(MaxSpriteWidth)) ? SizeW'(MaxSpriteWidth) : cfg_width_q;
    h_eff = (cfg_height_q == '0) ? SizeW'(1) :
            (cfg_height_q > SizeW'(MaxSpriteHeight)) ? SizeW'(MaxSpriteHeight) :
            cfg_height_q;
    nf_eff = (cfg_frames_q == '0) ? SizeW'(1) :
             (cfg_frames_q > SizeW'(MaxFrames)) ? SizeW'(MaxFrames) : cfg_frames_q;
    period_eff = (cfg_period_q == '0) ? PeriodW'(1) : cfg_period_q;

    cmd.x0          = x0_q;
    cmd.y0          = y0_q;
    cmd.width       = w_eff;
    cmd.height      = h_eff;
    cmd.transparent = cfg_transp_q;
    cmd.frame       = div_frame;
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      x0_q <= {pos_x_i[PosW-1], pos_x_i} -
              {{(PosW+1-OriginW){cfg_org_x_q[OriginW-1]}}, cfg_org_x_q};
      y0_q <= {pos_y_i[PosW-1], pos_y_i} -
              {{(PosW+1-OriginW){cfg_org_y_q[OriginW-1]}}, cfg_org_y_q};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (div_start) state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_WALK;
      S_WALK: if (walk_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  asbu_glyph_store u_store (
    .clk_i   (clk_i),
    .we_i    (accept && (action_i == ActLoad)),
    .waddr_i (load_address_i),
    .wdata_i (glyph_in_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  asbu_frame_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (elapsed_ms_i),
    .divisor_i  (period_eff),
    .modulus_i  (nf_eff),
    .done_o     (div_done),
    .frame_o    (div_frame)
  );

  asbu_pixel_walk u_walk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (walk_start),
    .cmd_i            (cmd),
    .done_o           (walk_done),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .screen_address_o (screen_address_o),
    .glyph_out_o      (glyph_out_o),
    .frame_index_o    (frame_index_o),
    .last_o           (last_o)
  );

  `ASBU_ASSERT_IMP(a_div_done_in_div, div_done, state_q == S_DIV)
  `ASBU_ASSERT_IMP(a_walk_done_in_walk, walk_done, state_q == S_WALK)
  `ASBU_ASSERT_IMP(a_out_from_walk, $rose(out_valid_o), $past(state_q) == S_WALK)

endmodule

`default_nettype wire

>>> tb/tb_animated_sprite_blitter_unit.sv
`timescale 1ns / 1ps

module tb_animated_sprite_blitter_unit;

  localparam int ClkHigh = 6;
  localparam int ClkLow = 6;
  localparam int DrainCycles = 160;
  localparam int LongHold = 300;
  localparam int PhaseItems = 20;
  localparam int RandomPhases = 8;
  localparam longint LimitNs = 8_000_000;
  localparam logic [asbu_pkg::CfgIdxW-1:0] CfgUnused = 3'd7;

  typedef struct packed {
    logic [asbu_pkg::ScreenAw-1:0] screen_address;
    logic [asbu_pkg::GlyphW-1:0]   glyph;
    logic [asbu_pkg::FrameW-1:0]   frame;
    logic                          last;
  } cell_write_t;

  class blit_scoreboard;
    cell_write_t expected_q[$];
    logic [asbu_pkg::GlyphW-1:0] glyph_mem [asbu_pkg::StoreDepth];
    logic [asbu_pkg::SizeW-1:0] width_reg, height_reg, frames_reg;
    logic [asbu_pkg::PeriodW-1:0] period_reg;
    bit transparent;
    int org_x, org_y;
    int errors, loads, draws, cells;

    function new();
      width_reg = 1;
      height_reg = 1;
      frames_reg = 1;
      period_reg = asbu_pkg::PeriodReset;
      transparent = 1'b0;
      org_x = 0;
      org_y = 0;
      errors = 0;
      loads = 0;
      draws = 0;
      cells = 0;
    endfunction

    function void report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function int unsigned saturate(int unsigned v, int unsigned hi);
      return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function int unsigned eff_w();
      return saturate(width_reg, asbu_pkg::MaxSpriteWidth);
    endfunction

    function int unsigned eff_h();
      return saturate(height_reg, asbu_pkg::MaxSpriteHeight);
    endfunction

    function int unsigned eff_nf();
      return saturate(frames_reg, asbu_pkg::MaxFrames);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [asbu_pkg::CfgIdxW-1:0] idx,
                          logic [asbu_pkg::CfgDataW-1:0] val);
      case (idx)
        asbu_pkg::CfgSpriteWidth:  width_reg = val[3:0];
        asbu_pkg::CfgSpriteHeight: height_reg = val[3:0];
        asbu_pkg::CfgFrameCount:   frames_reg = val[3:0];
        asbu_pkg::CfgFramePeriod:  period_reg = val;
        asbu_pkg::CfgTransparent:  transparent = val[0];
        asbu_pkg::CfgOriginX:      org_x = $signed(val[7:0]);
        asbu_pkg::CfgOriginY:      org_y = $signed(val[7:0]);
        default: ;
      endcase
    endfunction

    // loads update the glyph mirror, draws queue one cell write per visible pixel
    function void note_input(logic act, logic [asbu_pkg::StoreAw-1:0] addr,
                             logic [asbu_pkg::GlyphW-1:0] g,
                             logic signed [asbu_pkg::PosW-1:0] px,
                             logic signed [asbu_pkg::PosW-1:0] py,
                             logic [asbu_pkg::ElapsedW-1:0] el);
      int unsigned w, h, nf, per, frame_sel;
      int r, c, x0, y0, x, y, idx, n;
      logic [asbu_pkg::GlyphW-1:0] pix;
      cell_write_t cw;
      if (act == asbu_pkg::ActLoad) begin
        glyph_mem[addr] = g;
        loads++;
        return;
      end
      draws++;
      w = eff_w();
      h = eff_h();
      nf = eff_nf();
      per = (period_reg == 0) ? 1 : period_reg;
      frame_sel = (el / per) % nf;
      x0 = px;
      y0 = py;
      x0 = x0 - org_x;
      y0 = y0 - org_y;
      n = 0;
      for (r = 0; r < int'(h); r++) begin
        for (c = 0; c < int'(w); c++) begin
          x = x0 + c;
          y = y0 + r;
          idx = frame_sel * asbu_pkg::FrameSlot + r * w + c;
          pix = glyph_mem[idx];
          if (x >= 0 && y >= 0 && x < int'(asbu_pkg::ScreenCols) &&
              y < int'(asbu_pkg::ScreenRows) &&
              !(transparent && pix == asbu_pkg::SpaceGlyph)) begin
            cw.screen_address = y * asbu_pkg::ScreenCols + x;
            cw.glyph = pix;
            cw.frame = frame_sel;
            cw.last = 1'b0;
            expected_q.push_back(cw);
            n++;
          end
        end
      end
      if (n > 0) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [asbu_pkg::ScreenAw-1:0] sa,
                               logic [asbu_pkg::GlyphW-1:0] g,
                               logic [asbu_pkg::FrameW-1:0] fi, logic lst);
      cell_write_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected cell write addr %0d glyph %h", sa, g));
        return;
      end
      want = expected_q.pop_front();
      cells++;
      if (sa !== want.screen_address)
        report($sformatf("screen_address %0d, want %0d", sa, want.screen_address));
      if (g !== want.glyph)
        report($sformatf("glyph_out %h, want %h at addr %0d", g, want.glyph,
                         want.screen_address));
      if (fi !== want.frame)
        report($sformatf("frame_index %0d, want %0d", fi, want.frame));
      if (lst !== want.last)
        report($sformatf("last %b, want %b at addr %0d", lst, want.last,
                         want.screen_address));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic action_i;
  logic [asbu_pkg::StoreAw-1:0] load_address_i;
  logic [asbu_pkg::GlyphW-1:0] glyph_in_i;
  logic signed [asbu_pkg::PosW-1:0] pos_x_i;
  logic signed [asbu_pkg::PosW-1:0] pos_y_i;
  logic [asbu_pkg::ElapsedW-1:0] elapsed_ms_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [asbu_pkg::ScreenAw-1:0] screen_address_o;
  logic [asbu_pkg::GlyphW-1:0] glyph_out_o;
  logic [asbu_pkg::FrameW-1:0] frame_index_o;
  logic last_o;
  logic cfg_we_i;
  logic [asbu_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [asbu_pkg::CfgDataW-1:0] cfg_data_i;

  blit_scoreboard sb;
  bit loaded [asbu_pkg::StoreDepth];
  bit tx_idle_en;
  bit rx_idle_en;
  bit long_hold_req;
  int settings_count;

  animated_sprite_blitter_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .load_address_i  (load_address_i),
    .glyph_in_i      (glyph_in_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .elapsed_ms_i    (elapsed_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .screen_address_o(screen_address_o),
    .glyph_out_o     (glyph_out_o),
    .frame_index_o   (frame_index_o),
    .last_o          (last_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #(ClkLow);
    clk_i = 1'b1;
    #(ClkHigh);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(screen_address_o, glyph_out_o, frame_index_o, last_o);
  end

  // receiver side: random stall bursts, plus one long hold on request
  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #(LimitNs);
    $display("timeout with %0d cell writes still expected", sb.pending());
    $display("status: fail");
    $finish;
  end

  function automatic logic [asbu_pkg::GlyphW-1:0] pick_glyph();
    case ($urandom_range(0, 7))
      0, 1: return asbu_pkg::SpaceGlyph;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // valid stays high from one transaction to the next unless a gap is taken
  task automatic send_item(logic act, logic [asbu_pkg::StoreAw-1:0] addr,
                           logic [asbu_pkg::GlyphW-1:0] g,
                           logic signed [asbu_pkg::PosW-1:0] px,
                           logic signed [asbu_pkg::PosW-1:0] py,
                           logic [asbu_pkg::ElapsedW-1:0] el);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    load_address_i <= addr;
    glyph_in_i <= g;
    pos_x_i <= px;
    pos_y_i <= py;
    elapsed_ms_i <= el;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(act, addr, g, px, py, el);
  endtask

  task automatic load_glyph(int unsigned addr, logic [asbu_pkg::GlyphW-1:0] g);
    loaded[addr] = 1'b1;
    send_item(asbu_pkg::ActLoad, addr, g, $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom);
  endtask

  // every entry a draw can read under the current settings gets written first
  task automatic prime_store();
    int unsigned f, k, a;
    for (f = 0; f < sb.eff_nf(); f++) begin
      for (k = 0; k < sb.eff_w() * sb.eff_h(); k++) begin
        a = f * asbu_pkg::FrameSlot + k;
        if (!loaded[a]) load_glyph(a, pick_glyph());
      end
    end
  endtask

  task automatic draw_at(logic signed [asbu_pkg::PosW-1:0] px,
                         logic signed [asbu_pkg::PosW-1:0] py,
                         logic [asbu_pkg::ElapsedW-1:0] el);
    prime_store();
    send_item(asbu_pkg::ActDraw, $urandom_range(0, 511), pick_glyph(), px, py, el);
  endtask

  task automatic random_draw();
    logic signed [asbu_pkg::PosW-1:0] px, py;
    logic [asbu_pkg::ElapsedW-1:0] el;
    case ($urandom_range(0, 9))
      0, 1: begin
        px = $urandom_range(0, 65535);
        py = $urandom_range(0, 65535);
      end
      2: begin
        px = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        py = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
      default: begin
        // near the screen after the origin shift, edges included
        px = sb.org_x + $urandom_range(0, 145) - 10;
        py = sb.org_y + $urandom_range(0, 81) - 10;
      end
    endcase
    el = $urandom_range(0, 1) ? $urandom_range(0, 5000) : $urandom;
    draw_at(px, py, el);
  endtask

  task automatic write_reg(logic [asbu_pkg::CfgIdxW-1:0] idx,
                           logic [asbu_pkg::CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [9:0] w, logic [9:0] h, logic [9:0] nf,
                                logic [9:0] per, logic [9:0] tr,
                                logic [9:0] ox, logic [9:0] oy);
    write_reg(asbu_pkg::CfgSpriteWidth, w);
    write_reg(asbu_pkg::CfgSpriteHeight, h);
    write_reg(asbu_pkg::CfgFrameCount, nf);
    write_reg(asbu_pkg::CfgFramePeriod, per);
    write_reg(asbu_pkg::CfgTransparent, tr);
    write_reg(asbu_pkg::CfgOriginX, ox);
    write_reg(asbu_pkg::CfgOriginY, oy);
    settings_count++;
  endtask

  // a draw that writes nothing still keeps the block busy, so pad after the queue empties
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_phase();
    settle();
    apply_settings($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 20),
                   $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1023));
    repeat (PhaseItems) begin
      if ($urandom_range(0, 3) == 0) load_glyph($urandom_range(0, 511), pick_glyph());
      else random_draw();
    end
  endtask

  initial begin
    sb = new();
    settings_count = 1;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    long_hold_req = 1'b0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    action_i <= asbu_pkg::ActLoad;
    load_address_i <= '0;
    glyph_in_i <= '0;
    pos_x_i <= '0;
    pos_y_i <= '0;
    elapsed_ms_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: single pixel sprite, clipping at every screen edge
    load_glyph(0, 16'hFFFF);
    draw_at(0, 0, 0);
    draw_at(127, 63, 32'hFFFF_FFFF);
    draw_at(-1, 0, 5);
    draw_at(128, 0, 0);
    draw_at(0, 64, 0);
    draw_at(0, -1, 0);
    draw_at(-32768, 32767, 0);
    draw_at(32767, -32768, 1);
    load_glyph(0, asbu_pkg::SpaceGlyph);
    draw_at(64, 32, 999);
    load_glyph(511, 16'h0000);

    // largest sprite, all frames, transparency, origins at both extremes
    settle();
    apply_settings(8, 8, 8, 1, 1, 10'h080, 10'h07F);
    prime_store();
    long_hold_req = 1'b1;
    draw_at(-131, 124, 0);
    draw_at(-4, 187, 3);
    draw_at(-128, 127, 7);
    draw_at(-8, 122, 32'hFFFF_FFFF);
    draw_at(-60, 150, 12);

    // out of range sizes and counts saturate, zero period acts as one
    settle();
    apply_settings(15, 0, 15, 0, 0, 10'h07F, 10'h080);
    write_reg(CfgUnused, 10'h3FF);
    draw_at(127, -128, 5);
    draw_at(247, -70, 32'hFFFF_FFFF);
    draw_at(0, 0, 2);

    settle();
    apply_settings(0, 15, 0, 1023, 1, 10'h000, 10'h000);
    draw_at(0, 0, 32'hFFFF_FFFF);
    draw_at(127, 60, 1023);

    for (int p = 0; p < RandomPhases; p++) begin
      if (p == RandomPhases - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      random_phase();
    end

    settle();
    if (sb.pending() != 0) sb.report("draw results never arrived");
    $display("covered %0d loads and %0d draws, %0d cell writes checked", sb.loads,
             sb.draws, sb.cells);
    $display("over %0d register settings incl. saturated sizes, zero period, clipping",
             settings_count);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
